>>> src/kclc_pkg.sv
package kclc_pkg;

  localparam int CODE_LEN = 4;
  localparam int CNT_W    = $clog2(CODE_LEN + 1);
  localparam int KEY_W    = 4;
  localparam int CFG_W    = 32;
  localparam int LIMIT_W  = 3;

  localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

  localparam logic [CFG_W-1:0]   IDLE_TIMEOUT_RST  = 32'd288600;
  localparam logic [LIMIT_W-1:0] FAILURE_LIMIT_RST = 3'd3;

  typedef enum logic [0:0] {
    CFG_IDLE_TIMEOUT  = 1'b0,
    CFG_FAILURE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_ALARM   = 2'd1,
    MODE_MENU    = 2'd2,
    MODE_NEWCODE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_STORED    = 4'd1,
    EV_IGNORED   = 4'd2,
    EV_CORRECT   = 4'd3,
    EV_WRONG     = 4'd4,
    EV_ALARM     = 4'd5,
    EV_CLEARED   = 4'd6,
    EV_USERLOCK  = 4'd7,
    EV_TIMEOUT   = 4'd8,
    EV_CHANGED   = 4'd9,
    EV_BACKSPACE = 4'd10
  } event_t;

  typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_t;

  typedef struct packed {
    logic             tick;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    event_t event_res;
    logic   alarm_on;
    logic   unlocked;
    mode_t  mode;
  } result_t;

endpackage

>>> src/kclc_in_reg.sv
module kclc_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  kclc_pkg::item_t      in_item,
  input  logic                 out_free,
  output logic                 advance,
  output kclc_pkg::item_t      item
);

  logic            valid_r;
  logic            valid_nxt;
  kclc_pkg::item_t item_r;

  assign advance   = valid_r && out_free;
  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !advance);
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> src/kclc_core.sv
module kclc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  kclc_pkg::cfg_idx_t           cfg_index,
  input  logic [kclc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         advance,
  input  kclc_pkg::item_t              item,
  output kclc_pkg::result_t            result
);

  logic [kclc_pkg::CFG_W-1:0]   idle_timeout_r;
  logic [kclc_pkg::LIMIT_W-1:0] failure_limit_r;

  kclc_pkg::mode_t              mode_r,        mode_nxt;
  kclc_pkg::code_t              code_r,        code_nxt;
  kclc_pkg::code_t              buf_r,         buf_nxt;
  logic [kclc_pkg::CNT_W-1:0]   count_r,       count_nxt;
  logic [kclc_pkg::LIMIT_W-1:0] fail_r,        fail_nxt;
  logic [kclc_pkg::CFG_W-1:0]   idle_r,        idle_nxt;
  kclc_pkg::event_t             ev;

  logic                         match;
  logic                         full;
  logic [kclc_pkg::CFG_W-1:0]   idle_inc;
  logic [kclc_pkg::LIMIT_W-1:0] fail_inc;

  assign full     = (count_r == kclc_pkg::CNT_W'(kclc_pkg::CODE_LEN));
  assign match    = full && (buf_r == code_r);
  assign idle_inc = (&idle_r) ? idle_r : idle_r + 1'b1;
  assign fail_inc = fail_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r  <= kclc_pkg::IDLE_TIMEOUT_RST;
      failure_limit_r <= kclc_pkg::FAILURE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kclc_pkg::CFG_IDLE_TIMEOUT:  idle_timeout_r  <= cfg_wdata;
        kclc_pkg::CFG_FAILURE_LIMIT: failure_limit_r <= cfg_wdata[kclc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and event for the item in the input register
  always_comb begin
    mode_nxt  = mode_r;
    code_nxt  = code_r;
    buf_nxt   = buf_r;
    count_nxt = count_r;
    fail_nxt  = fail_r;
    idle_nxt  = idle_r;
    ev        = kclc_pkg::EV_NONE;

    if (item.tick) begin
      if (mode_r == kclc_pkg::MODE_MENU) begin
        idle_nxt = idle_inc;
        if (idle_inc > idle_timeout_r) begin
          mode_nxt  = kclc_pkg::MODE_ENTRY;
          count_nxt = '0;
          idle_nxt  = '0;
          ev        = kclc_pkg::EV_TIMEOUT;
        end
      end
    end else begin
      case (mode_r)
        kclc_pkg::MODE_MENU: begin
          idle_nxt = '0;
          if (item.key == kclc_pkg::KEY_A) begin
            mode_nxt  = kclc_pkg::MODE_ENTRY;
            count_nxt = '0;
            ev        = kclc_pkg::EV_USERLOCK;
          end else if (item.key == kclc_pkg::KEY_B) begin
            mode_nxt  = kclc_pkg::MODE_NEWCODE;
            buf_nxt   = '0;
            count_nxt = '0;
          end else begin
            ev = kclc_pkg::EV_IGNORED;
          end
        end
        default: begin
          if (item.key == kclc_pkg::KEY_HASH) begin
            count_nxt = '0;
            case (mode_r)
              kclc_pkg::MODE_ENTRY: begin
                if (match) begin
                  mode_nxt = kclc_pkg::MODE_MENU;
                  fail_nxt = '0;
                  idle_nxt = '0;
                  ev       = kclc_pkg::EV_CORRECT;
                end else if (fail_inc >= failure_limit_r) begin
                  mode_nxt = kclc_pkg::MODE_ALARM;
                  fail_nxt = '0;
                  ev       = kclc_pkg::EV_ALARM;
                end else begin
                  fail_nxt = fail_inc;
                  ev       = kclc_pkg::EV_WRONG;
                end
              end
              kclc_pkg::MODE_ALARM: begin
                if (match) begin
                  mode_nxt = kclc_pkg::MODE_ENTRY;
                  fail_nxt = '0;
                  ev       = kclc_pkg::EV_CLEARED;
                end else begin
                  ev = kclc_pkg::EV_WRONG;
                end
              end
              default: begin
                code_nxt = buf_r;
                mode_nxt = kclc_pkg::MODE_MENU;
                idle_nxt = '0;
                ev       = kclc_pkg::EV_CHANGED;
              end
            endcase
          end else if (item.key == kclc_pkg::KEY_STAR && mode_r != kclc_pkg::MODE_ALARM) begin
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
              ev        = kclc_pkg::EV_BACKSPACE;
            end else begin
              ev = kclc_pkg::EV_IGNORED;
            end
          end else if (!full) begin
            for (int i = 0; i < kclc_pkg::CODE_LEN; i++) begin
              if (count_r == kclc_pkg::CNT_W'(i)) begin
                buf_nxt[i] = item.key;
              end
            end
            count_nxt = count_r + 1'b1;
            ev        = kclc_pkg::EV_STORED;
          end else begin
            ev = kclc_pkg::EV_IGNORED;
          end
        end
      endcase
    end
  end

  always_comb begin
    result.mode      = mode_nxt;
    result.unlocked  = (mode_nxt == kclc_pkg::MODE_MENU) || (mode_nxt == kclc_pkg::MODE_NEWCODE);
    result.alarm_on  = (mode_nxt == kclc_pkg::MODE_ALARM);
    result.event_res = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= kclc_pkg::MODE_ENTRY;
      buf_r   <= '0;
      count_r <= '0;
      fail_r  <= '0;
      idle_r  <= '0;
      for (int i = 0; i < kclc_pkg::CODE_LEN; i++) begin
        code_r[i] <= kclc_pkg::KEY_W'((i + 1) % 10);
      end
    end else if (advance) begin
      mode_r  <= mode_nxt;
      code_r  <= code_nxt;
      buf_r   <= buf_nxt;
      count_r <= count_nxt;
      fail_r  <= fail_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

>>> src/kclc_out_reg.sv
module kclc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  kclc_pkg::result_t   result,
  output logic                out_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output kclc_pkg::result_t   out_result
);

  logic              valid_r;
  logic              valid_nxt;
  kclc_pkg::result_t result_r;

  assign out_free   = !valid_r || out_tready;
  assign valid_nxt  = advance || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

endmodule

>>> src/keypad_code_lock_controller_top.sv
// Keypad code lock: each request is a key press or a time tick and yields exactly one result
// with the mode after it, the lock and alarm flags and an event code. One request is taken
// every clock cycle while the downstream side is not stalled. A result is presented on the
// output after its request has gone through the input register and then one pass of the lock
// state logic into the result register. It can be taken at the following edge. While the
// downstream side is stalled, the result register holds its result and the input register
// takes a request only while it is empty. Configuration (idle timeout, failure limit) must
// only be written while no request is in flight.
module keypad_code_lock_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] key_code, [7:4] zero
  input  logic        in_tuser,   // [0] action (1 = tick)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] mode, [2] unlocked, [3] alarm_on, [7:4] event_res
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  kclc_pkg::item_t   in_item;
  kclc_pkg::item_t   item;
  kclc_pkg::result_t result;
  kclc_pkg::result_t out_result;
  kclc_pkg::cfg_idx_t cfg_idx;
  logic              advance;
  logic              out_free;

  assign in_item.tick = in_tuser;
  assign in_item.key  = in_tdata[kclc_pkg::KEY_W-1:0];
  assign cfg_idx      = kclc_pkg::cfg_idx_t'(cfg_index);
  assign out_tdata    = out_result;

  kclc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .out_free  (out_free),
    .advance   (advance),
    .item      (item)
  );

  kclc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  kclc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result)
  );

endmodule
